[src/stick_trigger_deadzone_scaler_core_macros.svh]
// Assertion macros for the stick and trigger dead-zone scaler.
// Taken in by the top level; no other dependencies.
`ifndef STICK_TRIGGER_DEADZONE_SCALER_CORE_MACROS_SVH
`define STICK_TRIGGER_DEADZONE_SCALER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Check a consequence in the same cycle as its condition.
`define STDS_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stds same-cycle check failed");
// Check a consequence in the cycle after its condition.
`define STDS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("stds next-cycle check failed");
`else
`define STDS_ASSERT_SAME(label, clk, rst, ante, cons)
`define STDS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[src/stds_pkg.sv]
// Shared types and constants for the stick and trigger dead-zone scaler.
// No dependencies; used by the top level and the serial arithmetic units.
package stds_pkg;

  // Fixed field widths
  localparam int FUNC_W = 2;
  localparam int RAW_W  = 16;
  localparam int EL_W   = 32;
  localparam int CFG_W  = 16;
  localparam int TRIG_W = 15;

  // Serial units: sixteen steps each for root and quotient
  localparam int SER_STEPS = 16;
  localparam int CNT_W     = 4;

  // Square root: 32-bit radicand, 16-bit root, two radicand bits per step
  localparam int RAD_W  = 32;
  localparam int ROOT_W = 16;
  localparam int SREM_W = ROOT_W + 2;

  // Division lane: 47-bit numerator, 32-bit divisor, 16-bit quotient
  localparam int NUM_W = 47;
  localparam int DEN_W = 32;
  localparam int QUO_W = 16;
  localparam int MUL_W = 17;

  // Register indexes
  localparam logic [1:0] CFG_INNER = 2'd0;
  localparam logic [1:0] CFG_OUTER = 2'd1;
  localparam logic [1:0] CFG_LOW   = 2'd2;
  localparam logic [1:0] CFG_HIGH  = 2'd3;

  // Register reset values
  localparam logic [15:0] INNER_RST = 16'd4000;
  localparam logic [15:0] OUTER_RST = 16'd28000;
  localparam logic [14:0] LOW_RST   = 15'd3000;
  localparam logic [14:0] HIGH_RST  = 15'd30000;

  // Control for a serial unit: load operands, then advance one step
  typedef struct packed {
    logic load;
    logic step;
  } ser_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_SQLD,
    ST_SQRT,
    ST_DEN,
    ST_NUMX,
    ST_NUMY,
    ST_NUMYL,
    ST_TMUL,
    ST_TLD,
    ST_DIV,
    ST_FIN
  } state_t;

endpackage

[src/stds_isqrt.sv]
// Digit-serial integer square root, two radicand bits per cycle while ctl.step is set.
// Depends on stds_pkg for widths and the control struct.
module stds_isqrt (
  input  logic                            clk,
  input  stds_pkg::ser_ctl_t              ctl,
  input  logic [stds_pkg::RAD_W-1:0]      rad,
  output logic [stds_pkg::ROOT_W-1:0]     root
);

  logic [stds_pkg::RAD_W-1:0]  rad_sh;
  logic [stds_pkg::SREM_W-1:0] rem;
  logic [stds_pkg::SREM_W+1:0] rem4;
  logic [stds_pkg::SREM_W+1:0] trial;
  logic                        ge;

  // Bring down two bits and try the next root bit
  always_comb begin
    rem4  = {rem, rad_sh[stds_pkg::RAD_W-1 -: 2]};
    trial = {2'b00, root, 2'b01};
    ge    = (rem4 >= trial);
  end

  // Load the radicand, then shift it out two bits a step
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rad_sh <= rad;
      rem    <= '0;
      root   <= '0;
    end else if (ctl.step) begin
      rad_sh <= {rad_sh[stds_pkg::RAD_W-3:0], 2'b00};
      rem    <= ge ? stds_pkg::SREM_W'(rem4 - trial) : stds_pkg::SREM_W'(rem4);
      root   <= {root[stds_pkg::ROOT_W-2:0], ge};
    end
  end

endmodule

[src/stds_div_lane.sv]
// Bit-serial restoring divider lane, one quotient bit per cycle while ctl.step is set.
// Depends on stds_pkg; the quotient must fit in QUO_W bits.
module stds_div_lane (
  input  logic                         clk,
  input  stds_pkg::ser_ctl_t           ctl,
  input  logic [stds_pkg::NUM_W-1:0]   num,
  input  logic [stds_pkg::DEN_W-1:0]   den,
  output logic [stds_pkg::QUO_W-1:0]   quo
);

  logic [stds_pkg::DEN_W-1:0] rem;
  logic [stds_pkg::DEN_W:0]   rem2;
  logic                       ge;

  // Shift in the next numerator bit and compare with the divisor
  always_comb begin
    rem2 = {rem, quo[stds_pkg::QUO_W-1]};
    ge   = (rem2 >= {1'b0, den});
  end

  // The low numerator bits share one shift register with the quotient
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rem <= stds_pkg::DEN_W'(num[stds_pkg::NUM_W-1:stds_pkg::QUO_W]);
      quo <= num[stds_pkg::QUO_W-1:0];
    end else if (ctl.step) begin
      rem <= ge ? stds_pkg::DEN_W'(rem2 - {1'b0, den}) : stds_pkg::DEN_W'(rem2);
      quo <= {quo[stds_pkg::QUO_W-2:0], ge};
    end
  end

endmodule

[src/stick_trigger_deadzone_scaler_core.sv]
// Top level of the stick and trigger dead-zone scaler.
// Depends on stds_pkg, stds_isqrt, stds_div_lane and the macros header.
//
//  channel   dir  handshake                  payload (low bits first)
//  s_axis    in   s_axis_tvalid/tready       tdata: raw_x, raw_y, elapsed_ms; tuser: func
//  m_axis    out  m_axis_tvalid/tready       tdata: out_x, out_y, active_time; tuser: unit_active
//  cfg       in   cfg_we (no wait)           cfg_index, cfg_data
//
// A stick request passes from acceptance to the result register through two squares on the
// shared multiplier, one root load, 16 root steps, four setup states, 16 divide steps and
// one finish.
// A trigger request takes one product, one setup state, 16 divide steps and one finish.
// A request for an absent unit skips to the finish. One request is in flight at a time.
// The finish cycle holds while the result register is still full. Reset is synchronous.
`include "stick_trigger_deadzone_scaler_core_macros.svh"
module stick_trigger_deadzone_scaler_core #(
  parameter int NUM_STICKS   = 2,
  parameter int NUM_TRIGGERS = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // raw_x[15:0], raw_y[31:16], elapsed_ms[63:32]
  input  logic [1:0]  s_axis_tuser,   // func[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // out_x[15:0], out_y[31:16], active_time[63:32]
  output logic [0:0]  m_axis_tuser,   // unit_active[0]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int NUM_UNITS = NUM_STICKS + NUM_TRIGGERS;
  localparam int SIDX_W    = (NUM_STICKS > 1) ? $clog2(NUM_STICKS) : 1;
  localparam int TIDX_W    = (NUM_TRIGGERS > 1) ? $clog2(NUM_TRIGGERS) : 1;
  localparam int UIDX_W    = $clog2(NUM_UNITS);

  // Configuration registers
  logic [15:0] inner;
  logic [15:0] outer;
  logic [14:0] low_lvl;
  logic [14:0] high_lvl;

  // Request held while it is worked on
  stds_pkg::state_t                 state, state_next;
  logic [stds_pkg::CNT_W-1:0]       cnt;
  logic [stds_pkg::FUNC_W-1:0]      func;
  logic [15:0]                      raw_x;
  logic [15:0]                      raw_y;
  logic [31:0]                      elapsed_ms;

  // Shared multiplier and intermediate results
  logic [stds_pkg::MUL_W-1:0]       opa, opb;
  logic                             mul_en;
  logic [31:0]                      prod;
  logic [31:0]                      sqacc;
  logic [stds_pkg::DEN_W-1:0]       den;
  logic                             zero_r, mid_r;

  // Serial units
  stds_pkg::ser_ctl_t               sq_ctl, dx_ctl, dy_ctl;
  logic [stds_pkg::ROOT_W-1:0]      root;
  logic [stds_pkg::NUM_W-1:0]       num_x, num_y;
  logic [stds_pkg::QUO_W-1:0]       qx, qy;

  // Per-axis and per-unit state
  logic signed [15:0] stick_last_x [NUM_STICKS];
  logic signed [15:0] stick_last_y [NUM_STICKS];
  logic               stick_flag_x [NUM_STICKS];
  logic               stick_flag_y [NUM_STICKS];
  logic signed [15:0] trig_last    [NUM_TRIGGERS];
  logic               trig_flag    [NUM_TRIGGERS];
  logic [31:0]        total        [NUM_UNITS];

  // Decoded operands
  logic [16:0]        absx, absy;
  logic [14:0]        trig_t;
  logic [15:0]        m_minus_in;
  logic               tz, tstep;
  logic               is_stick, is_trig;
  logic [SIDX_W-1:0]  sidx;
  logic [TIDX_W-1:0]  tidx;
  logic [UIDX_W-1:0]  uidx;

  // Finish-cycle results
  logic               out_free, fin_fire, in_fire;
  logic signed [15:0] vx, vy, stx, sty, stt;
  logic               now_x, now_y, now_t;
  logic               act_x, act_y, act_t, act;
  logic [31:0]        tot_next;
  logic [15:0]        res_x, res_y;

  assign s_axis_tready = (state == stds_pkg::ST_IDLE) && !rst;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign fin_fire      = (state == stds_pkg::ST_FIN) && out_free;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      inner    <= stds_pkg::INNER_RST;
      outer    <= stds_pkg::OUTER_RST;
      low_lvl  <= stds_pkg::LOW_RST;
      high_lvl <= stds_pkg::HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        stds_pkg::CFG_INNER: inner    <= cfg_data;
        stds_pkg::CFG_OUTER: outer    <= cfg_data;
        stds_pkg::CFG_LOW:   low_lvl  <= cfg_data[14:0];
        stds_pkg::CFG_HIGH:  high_lvl <= cfg_data[14:0];
      endcase
    end
  end

  // Decode the held request
  always_comb begin
    absx       = raw_x[15] ? (17'd0 - {raw_x[15], raw_x}) : {1'b0, raw_x};
    absy       = raw_y[15] ? (17'd0 - {raw_y[15], raw_y}) : {1'b0, raw_y};
    trig_t     = raw_x[15] ? 15'd0 : raw_x[14:0];
    m_minus_in = 16'(root - inner);
    tz         = (trig_t <= low_lvl);
    tstep      = (high_lvl <= low_lvl) || (trig_t >= high_lvl);
    is_stick   = int'(func) < NUM_STICKS;
    is_trig    = !is_stick && (int'(func) < NUM_UNITS);
    sidx       = SIDX_W'(func);
    tidx       = TIDX_W'(func - stds_pkg::FUNC_W'(NUM_STICKS));
    uidx       = UIDX_W'(func);
  end

  // Select multiplier operands
  always_comb begin
    mul_en = 1'b1;
    unique case (state)
      stds_pkg::ST_SQX:  begin opa = absx; opb = absx; end
      stds_pkg::ST_SQY:  begin opa = absy; opb = absy; end
      stds_pkg::ST_DEN:  begin opa = {1'b0, 16'(outer - inner)}; opb = {1'b0, root}; end
      stds_pkg::ST_NUMX: begin opa = absx; opb = {1'b0, m_minus_in}; end
      stds_pkg::ST_NUMY: begin opa = absy; opb = {1'b0, m_minus_in}; end
      stds_pkg::ST_TMUL: begin opa = {2'b00, trig_t}; opb = {2'b00, 15'(trig_t - low_lvl)}; end
      default: begin
        opa    = '0;
        opb    = '0;
        mul_en = 1'b0;
      end
    endcase
  end

  // Numerators for the two divide lanes
  always_comb begin
    if (state == stds_pkg::ST_TLD) begin
      if (tz) begin
        num_x = '0;
      end else if (tstep) begin
        num_x = {32'd0, trig_t};
      end else begin
        num_x = {17'd0, prod[29:0]};
      end
      num_y = '0;
    end else begin
      if (zero_r) begin
        num_x = '0;
        num_y = '0;
      end else if (mid_r) begin
        num_x = {prod, 15'd0};
        num_y = {prod, 15'd0};
      end else begin
        num_x = {15'd0, absx, 15'd0};
        num_y = {15'd0, absy, 15'd0};
      end
    end
  end

  // Drive serial unit controls
  always_comb begin
    sq_ctl.load = (state == stds_pkg::ST_SQLD);
    sq_ctl.step = (state == stds_pkg::ST_SQRT);
    dx_ctl.load = (state == stds_pkg::ST_NUMY) || (state == stds_pkg::ST_TLD);
    dx_ctl.step = (state == stds_pkg::ST_DIV);
    dy_ctl.load = (state == stds_pkg::ST_NUMYL) || (state == stds_pkg::ST_TLD);
    dy_ctl.step = (state == stds_pkg::ST_DIV);
  end

  stds_isqrt u_isqrt (
    .clk  (clk),
    .ctl  (sq_ctl),
    .rad  (sqacc + prod),
    .root (root)
  );

  stds_div_lane u_div_x (
    .clk (clk),
    .ctl (dx_ctl),
    .num (num_x),
    .den (den),
    .quo (qx)
  );

  stds_div_lane u_div_y (
    .clk (clk),
    .ctl (dy_ctl),
    .num (num_y),
    .den (den),
    .quo (qy)
  );

  // Advance the sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      stds_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (int'(s_axis_tuser) < NUM_STICKS) begin
            state_next = stds_pkg::ST_SQX;
          end else if (int'(s_axis_tuser) < NUM_UNITS) begin
            state_next = stds_pkg::ST_TMUL;
          end else begin
            state_next = stds_pkg::ST_FIN;
          end
        end
      end
      stds_pkg::ST_SQX:   state_next = stds_pkg::ST_SQY;
      stds_pkg::ST_SQY:   state_next = stds_pkg::ST_SQLD;
      stds_pkg::ST_SQLD:  state_next = stds_pkg::ST_SQRT;
      stds_pkg::ST_SQRT: begin
        if (cnt == stds_pkg::CNT_W'(stds_pkg::SER_STEPS - 1)) begin
          state_next = stds_pkg::ST_DEN;
        end
      end
      stds_pkg::ST_DEN:   state_next = stds_pkg::ST_NUMX;
      stds_pkg::ST_NUMX:  state_next = stds_pkg::ST_NUMY;
      stds_pkg::ST_NUMY:  state_next = stds_pkg::ST_NUMYL;
      stds_pkg::ST_NUMYL: state_next = stds_pkg::ST_DIV;
      stds_pkg::ST_TMUL:  state_next = stds_pkg::ST_TLD;
      stds_pkg::ST_TLD:   state_next = stds_pkg::ST_DIV;
      stds_pkg::ST_DIV: begin
        if (cnt == stds_pkg::CNT_W'(stds_pkg::SER_STEPS - 1)) begin
          state_next = stds_pkg::ST_FIN;
        end
      end
      stds_pkg::ST_FIN: begin
        if (out_free) begin
          state_next = stds_pkg::ST_IDLE;
        end
      end
      default: state_next = stds_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stds_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Count serial steps
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if ((state == stds_pkg::ST_SQRT) || (state == stds_pkg::ST_DIV)) begin
      cnt <= cnt + 1'b1;
    end else begin
      cnt <= '0;
    end
  end

  // Capture the request and hold intermediate products
  always_ff @(posedge clk) begin
    if (in_fire) begin
      func       <= s_axis_tuser;
      raw_x      <= s_axis_tdata[15:0];
      raw_y      <= s_axis_tdata[31:16];
      elapsed_ms <= s_axis_tdata[63:32];
    end
    if (mul_en) begin
      prod <= 32'(opa * opb);
    end
    if (state == stds_pkg::ST_SQY) begin
      sqacc <= prod;
    end
    if (state == stds_pkg::ST_DEN) begin
      zero_r <= (root <= inner);
      mid_r  <= (root > inner) && (outer > inner) && (root < outer);
    end
    if (state == stds_pkg::ST_NUMX) begin
      den <= zero_r ? 32'd1 : (mid_r ? prod : {16'd0, root});
    end else if (state == stds_pkg::ST_TLD) begin
      den <= (tz || tstep) ? 32'd1 : {17'd0, 15'(high_lvl - low_lvl)};
    end
  end

  // Apply sign and saturation, then update axis activity
  always_comb begin
    vx    = raw_x[15] ? $signed(16'(16'd0 - qx)) : $signed(qx[15] ? 16'h7FFF : qx);
    vy    = raw_y[15] ? $signed(16'(16'd0 - qy)) : $signed(qy[15] ? 16'h7FFF : qy);
    now_x = (vx > 16'sd3) || (vx < -16'sd3);
    now_y = (vy > 16'sd3) || (vy < -16'sd3);
    stx   = now_x ? vx : 16'sd0;
    sty   = now_y ? vy : 16'sd0;
    act_x = now_x || stick_flag_x[sidx] ||
            ((stx <= 16'sd0) != (stick_last_x[sidx] <= 16'sd0));
    act_y = now_y || stick_flag_y[sidx] ||
            ((sty <= 16'sd0) != (stick_last_y[sidx] <= 16'sd0));
    stt   = $signed(qx);
    now_t = (qx != '0);
    act_t = now_t || trig_flag[tidx] ||
            ((stt <= 16'sd0) != (trig_last[tidx] <= 16'sd0));
    act   = is_stick ? (act_x || act_y) : act_t;
    tot_next = act ? (total[uidx] + elapsed_ms) : 32'd0;
    if (is_stick) begin
      res_x = stx;
      res_y = sty;
    end else begin
      res_x = stt;
      res_y = '0;
    end
  end

  // Commit axis and unit state on finish
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_STICKS; i++) begin
        stick_last_x[i] <= '0;
        stick_last_y[i] <= '0;
        stick_flag_x[i] <= 1'b0;
        stick_flag_y[i] <= 1'b0;
      end
      for (int i = 0; i < NUM_TRIGGERS; i++) begin
        trig_last[i] <= '0;
        trig_flag[i] <= 1'b0;
      end
      for (int i = 0; i < NUM_UNITS; i++) begin
        total[i] <= '0;
      end
    end else if (fin_fire) begin
      if (is_stick) begin
        stick_last_x[sidx] <= stx;
        stick_last_y[sidx] <= sty;
        stick_flag_x[sidx] <= now_x;
        stick_flag_y[sidx] <= now_y;
        total[uidx]        <= tot_next;
      end else if (is_trig) begin
        trig_last[tidx] <= stt;
        trig_flag[tidx] <= now_t;
        total[uidx]     <= tot_next;
      end
    end
  end

  // Hold the result until the consumer takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (fin_fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_fire) begin
      if (is_stick || is_trig) begin
        m_axis_tdata <= {tot_next, res_y, res_x};
        m_axis_tuser <= act;
      end else begin
        m_axis_tdata <= '0;
        m_axis_tuser <= 1'b0;
      end
    end
  end

  // A request leaves the idle state on the next cycle
  `STDS_ASSERT_NEXT(a_accept_leaves_idle, clk, rst, in_fire, state != stds_pkg::ST_IDLE)
  // Stick quotients never exceed full scale plus one
  `STDS_ASSERT_SAME(a_stick_quo_bound, clk, rst, (state == stds_pkg::ST_FIN) && is_stick, (qx <= 16'h8000) && (qy <= 16'h8000))
  // Trigger value never exceeds its input and the spare lane stays zero
  `STDS_ASSERT_SAME(a_trig_quo_bound, clk, rst, (state == stds_pkg::ST_FIN) && is_trig, (qx <= {1'b0, trig_t}) && (qy == '0))

endmodule
